// ===== rtl/core/whcc_pkg.sv =====
package whcc_pkg;

   localparam int MaxHashBits = 16;
   localparam int HashLimit   = (MaxHashBits < 16) ? MaxHashBits : 16;
   localparam int MapAddrBits = MaxHashBits;

   localparam int HashWidth  = 16;
   localparam int PadWidth   = 4;
   localparam int LenWidth   = 5;
   localparam int ModeWidth  = 2;
   localparam int CountWidth = 24;
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = 2;
   localparam int QueueCntBits = 3;

   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;

   typedef enum logic [ModeWidth-1:0] {
      MODE_SUM     = 2'd0,
      MODE_PRODUCT = 2'd1,
      MODE_FOLD    = 2'd2,
      MODE_SPARE   = 2'd3
   } mode_type;

   typedef enum logic {
      REG_HASH_MODE = 1'b0,
      REG_HASH_BITS = 1'b1
   } reg_index_type;

   typedef struct packed {
      mode_type              mode;
      logic [LenWidth-1:0]   eff_bits;
      logic                  restart;
   } cfg_type;

   typedef struct packed {
      logic [PadWidth-1:0]   pad;
      logic [HashWidth-1:0]  value;
   } hq_type;

   typedef struct packed {
      logic [CountWidth-1:0] total;
      logic                  collided;
      logic [HashWidth-1:0]  hash;
   } rsp_type;

   function automatic logic [HashWidth-1:0] hash_mask(input logic [LenWidth-1:0] len);
      logic [HashWidth:0] wide;
      begin
         wide = ((HashWidth+1)'(1) << len) - (HashWidth+1)'(1);
         return wide[HashWidth-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/whcc_csr.sv =====
module whcc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [whcc_pkg::CsrAddrBits-1:0]   csr_paddr,
   input  logic [whcc_pkg::CsrDataBits-1:0]   csr_pwdata,
   output logic [whcc_pkg::CsrDataBits-1:0]   csr_prdata,
   output logic                               csr_pready,
   output whcc_pkg::cfg_type                  cfg
);

   logic [whcc_pkg::ModeWidth-1:0] mode_ff, mode_in;
   logic [whcc_pkg::LenWidth-1:0]  bits_ff, bits_in;
   logic                           restart_ff, restart_in;
   logic                           wr_en;
   whcc_pkg::reg_index_type        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = whcc_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      mode_in    = mode_ff;
      bits_in    = bits_ff;
      restart_in = wr_en;
      if (wr_en) begin
         unique case (reg_sel)
            whcc_pkg::REG_HASH_MODE: mode_in = csr_pwdata[whcc_pkg::ModeWidth-1:0];
            whcc_pkg::REG_HASH_BITS: bits_in = csr_pwdata[whcc_pkg::LenWidth-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= whcc_pkg::MODE_SUM;
         bits_ff    <= whcc_pkg::LenWidth'(8);
         restart_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         bits_ff    <= bits_in;
         restart_ff <= restart_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         whcc_pkg::REG_HASH_MODE: csr_prdata[whcc_pkg::ModeWidth-1:0] = mode_ff;
         whcc_pkg::REG_HASH_BITS: csr_prdata[whcc_pkg::LenWidth-1:0]  = bits_ff;
      endcase
   end

   // Clamp the kept width to 1..HashLimit.
   always_comb begin
      cfg.mode = whcc_pkg::mode_type'(mode_ff);
      if (bits_ff == '0) begin
         cfg.eff_bits = whcc_pkg::LenWidth'(1);
      end else if (bits_ff > whcc_pkg::LenWidth'(whcc_pkg::HashLimit)) begin
         cfg.eff_bits = whcc_pkg::LenWidth'(whcc_pkg::HashLimit);
      end else begin
         cfg.eff_bits = bits_ff;
      end
      cfg.restart = restart_ff;
   end

endmodule

// ===== rtl/core/whcc_fifo.sv =====
module whcc_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  whcc_pkg::hq_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output whcc_pkg::hq_type pop_data
);

   whcc_pkg::hq_type                  entry_ff [whcc_pkg::QueueDepth];
   logic [whcc_pkg::QueuePtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [whcc_pkg::QueuePtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [whcc_pkg::QueueCntBits-1:0] count_ff, count_in;
   logic                              do_push, do_pop;

   assign full      = (count_ff == whcc_pkg::QueueCntBits'(whcc_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + whcc_pkg::QueuePtrBits'(do_push);
      rd_ptr_in = rd_ptr_ff + whcc_pkg::QueuePtrBits'(do_pop);
      count_in  = count_ff + whcc_pkg::QueueCntBits'(do_push)
                  - whcc_pkg::QueueCntBits'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/whcc_front.sv =====
module whcc_front (
   input  logic              clock,
   input  logic              reset,
   input  whcc_pkg::cfg_type cfg,
   input  logic              clearing,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              queue_full,
   output logic              queue_push,
   output whcc_pkg::hq_type  queue_data
);

   logic [whcc_pkg::HashWidth-1:0] running_ff, running_in, running_cur;
   logic [whcc_pkg::PadWidth-1:0]  offset_ff, offset_in, offset_cur;
   logic [whcc_pkg::HashWidth-1:0] step_value, fold_value, start_value;
   logic [whcc_pkg::LenWidth-1:0]  pos;
   logic [23:0]                    product;
   logic                           accept;

   assign req_tready  = ~clearing & ~queue_full;
   assign accept      = req_tvalid & req_tready;
   assign start_value = (cfg.mode == whcc_pkg::MODE_PRODUCT) ? whcc_pkg::HashWidth'(1) : '0;

   // In the cycle after a register write the word starts over under the new settings,
   // so a word taken in that cycle is hashed from the start value.
   assign running_cur = cfg.restart ? start_value : running_ff;
   assign offset_cur  = cfg.restart ? '0 : offset_ff;
   assign product     = running_cur * req_tdata;

   // Each set bit lands at the running bit position, which wraps at the kept width.
   always_comb begin
      fold_value = running_cur;
      pos        = {1'b0, offset_cur};
      for (int b = 0; b < 8; b++) begin
         if (req_tdata[b]) begin
            fold_value[pos[whcc_pkg::PadWidth-1:0]] = ~fold_value[pos[whcc_pkg::PadWidth-1:0]];
         end
         if (pos + whcc_pkg::LenWidth'(1) == cfg.eff_bits) begin
            pos = '0;
         end else begin
            pos = pos + whcc_pkg::LenWidth'(1);
         end
      end
   end

   always_comb begin
      unique case (cfg.mode)
         whcc_pkg::MODE_PRODUCT: step_value = product[whcc_pkg::HashWidth-1:0];
         whcc_pkg::MODE_FOLD:    step_value = fold_value;
         default:                step_value = running_cur + whcc_pkg::HashWidth'(req_tdata);
      endcase
   end

   always_comb begin
      queue_data.value = step_value & whcc_pkg::hash_mask(cfg.eff_bits);
      if (cfg.mode == whcc_pkg::MODE_FOLD && pos != '0) begin
         queue_data.pad = whcc_pkg::PadWidth'(cfg.eff_bits - pos);
      end else begin
         queue_data.pad = '0;
      end
      queue_push = accept & req_tlast;
   end

   always_comb begin
      running_in = running_cur;
      offset_in  = offset_cur;
      if (accept && req_tlast) begin
         running_in = start_value;
         offset_in  = '0;
      end else if (accept) begin
         running_in = step_value;
         offset_in  = pos[whcc_pkg::PadWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         offset_ff  <= '0;
      end else begin
         running_ff <= running_in;
         offset_ff  <= offset_in;
      end
   end

endmodule

// ===== rtl/core/whcc_back.sv =====
module whcc_back (
   input  logic              clock,
   input  logic              reset,
   input  whcc_pkg::cfg_type cfg,
   output logic              clearing,
   input  logic              queue_valid,
   input  whcc_pkg::hq_type  queue_data,
   output logic              queue_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output whcc_pkg::rsp_type rsp_word
);

   localparam int MapDepth = 1 << whcc_pkg::MapAddrBits;

   logic                                seen_mem [MapDepth];
   logic                                rd_bit_ff;

   logic                                clearing_ff, clearing_in;
   logic [whcc_pkg::MapAddrBits-1:0]    clr_addr_ff, clr_addr_in;

   logic                                s1_valid_ff, s1_valid_in;
   logic [whcc_pkg::HashWidth-1:0]      s1_hash_ff, s1_hash_in;
   logic                                s2_valid_ff, s2_valid_in;
   logic [whcc_pkg::HashWidth-1:0]      s2_hash_ff;
   logic                                fwd_ff, fwd_in;
   logic [whcc_pkg::CountWidth-1:0]     count_ff, count_in;

   whcc_pkg::rsp_type                   out_ff [2];
   logic [1:0]                          out_count_ff, out_count_in;

   logic [whcc_pkg::MapAddrBits-1:0]    s1_idx, s2_idx;
   logic [2*whcc_pkg::HashWidth-1:0]    rot_wide;
   logic [whcc_pkg::HashWidth-1:0]      rot_hash;
   logic [whcc_pkg::LenWidth-1:0]       rest_shift;
   logic                                out_pop, s1_move, hit;
   logic [2:0]                          occupancy;
   whcc_pkg::rsp_type                   result;

   assign clearing = clearing_ff;
   assign s1_idx   = whcc_pkg::MapAddrBits'(s1_hash_ff);
   assign s2_idx   = whcc_pkg::MapAddrBits'(s2_hash_ff);

   // Undo the zero padding of the fold: rotate left by pad within the kept width.
   always_comb begin
      rest_shift = cfg.eff_bits - whcc_pkg::LenWidth'(queue_data.pad);
      rot_wide   = (2*whcc_pkg::HashWidth)'(queue_data.value) << queue_data.pad;
      rot_hash   = (rot_wide[whcc_pkg::HashWidth-1:0] | (queue_data.value >> rest_shift))
                   & whcc_pkg::hash_mask(cfg.eff_bits);
      if (queue_data.pad == '0) begin
         rot_hash = queue_data.value;
      end
   end

   // S2 never holds a word back, so S1 may only move on when the output buffer is sure
   // to have room for it in the cycle after.
   always_comb begin
      out_pop   = rsp_tvalid & rsp_tready;
      occupancy = 3'(out_count_ff) + 3'(s2_valid_ff) - 3'(out_pop);
      s1_move   = s1_valid_ff & (occupancy < 3'd2);
      queue_pop = queue_valid & ~clearing_ff & (~s1_valid_ff | s1_move);

      s1_valid_in = queue_pop | (s1_valid_ff & ~s1_move);
      s1_hash_in  = queue_pop ? rot_hash : s1_hash_ff;
      s2_valid_in = s1_move;
      // The word in S2 writes its bit at the same edge at which S1's read is taken.
      fwd_in      = s1_move & s2_valid_ff & (s2_idx == s1_idx);
   end

   always_comb begin
      hit      = rd_bit_ff | fwd_ff;
      count_in = count_ff;
      if (s2_valid_ff && hit && count_ff != whcc_pkg::CountMax) begin
         count_in = count_ff + whcc_pkg::CountWidth'(1);
      end
      result.hash     = s2_hash_ff;
      result.collided = hit;
      result.total    = count_in;
      out_count_in    = out_count_ff + 2'(s2_valid_ff) - 2'(out_pop);
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + whcc_pkg::MapAddrBits'(1);
         if (clr_addr_ff == {whcc_pkg::MapAddrBits{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         count_ff     <= '0;
         out_count_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         count_ff     <= count_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_hash_ff <= s1_hash_in;
      if (s1_move) begin
         s2_hash_ff <= s1_hash_ff;
      end
      fwd_ff <= fwd_in;
      // A new result goes to the head when the buffer is empty after this pop,
      // otherwise behind whatever stays.
      if (s2_valid_ff && (out_count_ff - 2'(out_pop)) == 2'd0) begin
         out_ff[0] <= result;
      end else if (out_pop) begin
         out_ff[0] <= out_ff[1];
      end
      if (s2_valid_ff && (out_count_ff - 2'(out_pop)) != 2'd0) begin
         out_ff[1] <= result;
      end
   end

   // Seen bitmap: one write port and one registered read port.
   always_ff @(posedge clock) begin
      rd_bit_ff <= seen_mem[s1_idx];
      if (clearing_ff) begin
         seen_mem[clr_addr_ff] <= 1'b0;
      end else if (s2_valid_ff) begin
         seen_mem[s2_idx] <= 1'b1;
      end
   end

   assign rsp_tvalid = (out_count_ff != 2'd0);
   assign rsp_word   = out_ff[0];

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !queue_pop)
      else $error("queue popped during bitmap clear");

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (out_count_ff - 2'(out_pop)) != 2'd2)
      else $error("output buffer overflow");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("collision count went down");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && hit) |-> count_in != '0)
      else $error("collision reported with zero total");

endmodule

// ===== rtl/core/word_hash_collision_counter_unit.sv =====
// Channel  Dir  Handshake                    Payload
// req      in   req_tvalid / req_tready      tdata = char_byte, tlast = last_char
// rsp      out  rsp_tvalid / rsp_tready      tdata = hash_value, collided, collision_total
// csr      in   csr_psel / csr_penable       hash_mode at 0x0, hash_bits at 0x4
//
// One byte is taken per cycle while req is ready; the fold over a byte is a short chain
// in the front stage. After the edge that takes its last byte, a word's result passes
// through the queue with the rotate on its output, bitmap read, bitmap update. Words may
// end back to back. After reset the seen bitmap is cleared one entry per cycle, while req
// is held not ready. A stalled rsp side backs up into the four-entry queue, then into req.
module word_hash_collision_counter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] char_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [47:0]                        rsp_tdata,   // [15:0] hash_value,
                                                           // [16] collided,
                                                           // [40:17] collision_total
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [whcc_pkg::CsrAddrBits-1:0]   csr_paddr,
   input  logic [whcc_pkg::CsrDataBits-1:0]   csr_pwdata,
   output logic [whcc_pkg::CsrDataBits-1:0]   csr_prdata,
   output logic                               csr_pready
);

   whcc_pkg::cfg_type cfg;
   whcc_pkg::hq_type  push_data, pop_data;
   whcc_pkg::rsp_type rsp_word;
   logic              clearing, queue_full, queue_push, queue_valid, queue_pop;

   whcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   whcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .clearing   (clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (push_data)
   );

   whcc_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .pop_data  (pop_data)
   );

   whcc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .clearing    (clearing),
      .queue_valid (queue_valid),
      .queue_data  (pop_data),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_word    (rsp_word)
   );

   assign rsp_tdata = {7'd0, rsp_word.total, rsp_word.collided, rsp_word.hash};

endmodule

// ===== sim/word_hash_collision_counter_unit_tb.sv =====
module word_hash_collision_counter_unit_tb;

   localparam int WatchdogLimit = 300000;
   localparam int DrainCycles   = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata = '0;   // [7:0] char_byte
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [47:0]                      rsp_tdata;        // [15:0] hash_value, [16] collided,
                                                       // [40:17] collision_total
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [whcc_pkg::CsrAddrBits-1:0] csr_paddr = '0;
   logic [whcc_pkg::CsrDataBits-1:0] csr_pwdata = '0;
   logic [whcc_pkg::CsrDataBits-1:0] csr_prdata;
   logic                             csr_pready;

   word_hash_collision_counter_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Our own copy of the hashing state and its settings.
   whcc_pkg::mode_type cur_mode = whcc_pkg::MODE_SUM;
   logic [4:0]         cur_bits = 5'd8;
   int unsigned        running_hash = 0;
   int unsigned        char_offset = 0;
   bit                 seen_hashes [0:65535];
   logic [23:0]        collision_count = '0;
   whcc_pkg::rsp_type  word_hashes[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_rsp_cycles = 0;
   int mismatch_count = 0;
   int words_checked = 0;
   int collisions_seen = 0;
   int settings_used = 1;
   int quiet_cycles = 0;

   whcc_pkg::rsp_type got_word, want_word;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic restart_word();
      running_hash = (cur_mode == whcc_pkg::MODE_PRODUCT) ? 1 : 0;
      char_offset = 0;
   endtask

   // Updates the hash with one accepted byte and queues the result of a finished word.
   task automatic absorb_char(input logic [7:0] c, input logic last);
      int unsigned len, mask, off, pad, h;
      whcc_pkg::rsp_type r;
      len = cur_bits;
      if (len < 1) len = 1;
      if (len > whcc_pkg::HashLimit) len = whcc_pkg::HashLimit;
      mask = (1 << len) - 1;
      off = char_offset % len;
      case (cur_mode)
         whcc_pkg::MODE_PRODUCT: running_hash = (running_hash * c) & 32'hFFFF;
         whcc_pkg::MODE_FOLD: begin
            for (int b = 0; b < 8; b++)
               if (c[b]) running_hash ^= 1 << ((off + b) % len);
            running_hash &= 32'hFFFF;
         end
         default: running_hash = (running_hash + c) & 32'hFFFF;
      endcase
      off = (off + 8) % len;
      char_offset = off;
      if (last) begin
         h = running_hash & mask;
         if (cur_mode == whcc_pkg::MODE_FOLD) begin
            // Undo the MSB alignment of the final partial chunk.
            pad = (len - off) % len;
            if (pad != 0) h = ((h << pad) | (h >> (len - pad))) & mask;
         end
         r.hash = h[15:0];
         r.collided = seen_hashes[h];
         seen_hashes[h] = 1'b1;
         if (r.collided && collision_count != whcc_pkg::CountMax) collision_count++;
         r.total = collision_count;
         word_hashes = {word_hashes, r};
         restart_word();
      end
   endtask

   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      absorb_char(c, last);
   endtask

   task automatic send_word(input logic [7:0] chars[$]);
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
   endtask

   // Waits until every expected hash has come back and the pipeline has drained.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (word_hashes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input whcc_pkg::reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= whcc_pkg::CsrAddrBits'(4 * int'(idx));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == whcc_pkg::REG_HASH_MODE) cur_mode = whcc_pkg::mode_type'(value[1:0]);
      else cur_bits = value[4:0];
      restart_word();
      settings_used++;
      @(posedge clock);
   endtask

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch in %s: expected %0h, got %0h", what, want, got);
   endtask

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word = whcc_pkg::rsp_type'(rsp_tdata[40:0]);
         if (word_hashes.size() == 0) begin
            flag_mismatch("unexpected word result", 0, rsp_tdata);
         end else begin
            want_word = word_hashes.pop_front();
            words_checked++;
            if (want_word.collided) collisions_seen++;
            if (got_word.hash != want_word.hash)
               flag_mismatch("hash_value", want_word.hash, got_word.hash);
            if (got_word.collided != want_word.collided)
               flag_mismatch("collided", want_word.collided, got_word.collided);
            if (got_word.total != want_word.total)
               flag_mismatch("collision_total", want_word.total, got_word.total);
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_rsp_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_rsp_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // The bitmap clear after reset is the longest legal quiet stretch.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Timeout: nothing accepted for %0d cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_directed();
      send_word('{8'h00});
      send_word('{8'hFF});
      send_word('{8'h00});
      send_word('{8'h80, 8'h80, 8'h01});
      settle();
      write_reg(whcc_pkg::REG_HASH_MODE, whcc_pkg::MODE_PRODUCT);
      send_word('{8'hFF, 8'hFF});
      send_word('{8'h07, 8'h00, 8'h09});
      settle();
      write_reg(whcc_pkg::REG_HASH_MODE, whcc_pkg::MODE_FOLD);
      write_reg(whcc_pkg::REG_HASH_BITS, 32'd16);
      send_word('{8'hA5, 8'h3C, 8'h01});
      settle();
      write_reg(whcc_pkg::REG_HASH_BITS, 32'd5);
      send_word('{8'hFF, 8'h81});
      // A register write throws away the word in progress.
      send_char(8'h12, 1'b0);
      settle();
      write_reg(whcc_pkg::REG_HASH_BITS, 32'd1);
      send_word('{8'h01, 8'h02});
      settle();
      write_reg(whcc_pkg::REG_HASH_BITS, 32'd0);
      send_word('{8'h03});
      settle();
      write_reg(whcc_pkg::REG_HASH_BITS, 32'd31);
      send_word('{8'hFF, 8'h00, 8'hFF});
      settle();
      write_reg(whcc_pkg::REG_HASH_MODE, whcc_pkg::MODE_SPARE);
      send_word('{8'h10, 8'h20});
      settle();
   endtask

   task automatic send_random_word(output int sent);
      logic [7:0] chars[$];
      int len, kind;
      kind = $urandom_range(9);
      len = (kind == 0) ? $urandom_range(1, 20) : $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(3))
            0: chars = {chars, 8'h61 + 8'($urandom_range(3))};  // small alphabet repeats
            1: chars = {chars, ($urandom_range(1) ? 8'hFF : 8'h00)};
            default: chars = {chars, 8'($urandom)};
         endcase
      end
      // Now and then a word is cut short by a register write instead of ending.
      if (kind == 9) begin
         foreach (chars[i]) send_char(chars[i], 1'b0);
         settle();
         write_reg(whcc_pkg::REG_HASH_MODE, $urandom_range(3));
      end else begin
         send_word(chars);
      end
      sent = len;
   endtask

   task automatic test_random(input int send_pct, input int recv_pct, input int n_chars);
      int total, chunk, sent;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      total = 0;
      while (total < n_chars) begin
         settle();
         write_reg(whcc_pkg::REG_HASH_MODE, $urandom_range(3));
         write_reg(whcc_pkg::REG_HASH_BITS, $urandom_range(1) ? $urandom_range(1, 6)
                                                              : $urandom_range(0, 31));
         chunk = 0;
         while (chunk < 120) begin
            send_random_word(sent);
            chunk += sent;
         end
         total += chunk;
      end
      settle();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(whcc_pkg::REG_HASH_MODE, whcc_pkg::MODE_SUM);
      write_reg(whcc_pkg::REG_HASH_BITS, 32'd16);
      hold_rsp_cycles = 400;
      repeat (40) send_word('{8'($urandom)});
      settle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      test_directed();
      test_random(30, 63, 650);
      test_random(63, 30, 650);
      test_random(0, 0, 650);
      test_backpressure();
      repeat (20) @(posedge clock);
      $display("Checked %0d word hashes, %0d of them collisions, across %0d register writes,",
               words_checked, collisions_seen, settings_used - 1);
      $display("three idle patterns on both sides and a long output stall.");
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
